// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every clock edge outside reset.
`define DBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that holds on every clock edge, reset included.
`define DBL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dbl_pkg.sv =====
// Package for the button debounce block: sizes, codes, reset values and
// the structs passed between the lanes, the merge stage and the top level.
package dbl_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int CNT_W       = 16;
    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ_SHORT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_LONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS  = 2'd2;

    localparam logic             RST_PRESSED_LEVEL = 1'b0;
    localparam logic [CNT_W-1:0] RST_LONG_TICKS    = 16'd300;
    localparam logic [CNT_W-1:0] RST_REPEAT_TICKS  = 16'd100;
    localparam logic             RST_RELEASED      = ~RST_PRESSED_LEVEL;

    typedef struct packed {
        logic             pressed_level;
        logic [CNT_W-1:0] long_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic raw;
        logic clr_sp;
        logic clr_lp;
    } t_lane_ctrl;

    typedef struct packed {
        logic sp_cur;
        logic lp_cur;
        logic sp_nxt;
        logic lp_nxt;
    } t_lane_flags;

endpackage

// ===== hw/rtl/dbl_lane.sv =====
// One button lane: sample stages, accepted level, hold counter,
// repeat mode and the short and long press flags. Depends on dbl_pkg.
module dbl_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dbl_pkg::t_cfg        i_cfg,
    input  dbl_pkg::t_lane_ctrl  i_ctrl,
    output dbl_pkg::t_lane_flags o_flags
);
    import dbl_pkg::*;

    logic             r_s1, r_s2, r_acc, r_rep, r_sf, r_lf;
    logic             n_s1, n_s2, n_acc, n_rep, n_sf, n_lf;
    logic [CNT_W-1:0] r_cnt, n_cnt, w_dec;

    assign w_dec = (r_cnt != '0) ? r_cnt - CNT_W'(1) : r_cnt;

    always_comb begin
        n_s1  = r_s1;
        n_s2  = r_s2;
        n_acc = r_acc;
        n_rep = r_rep;
        n_sf  = r_sf;
        n_lf  = r_lf;
        n_cnt = r_cnt;
        if (i_ctrl.tick) begin
            n_s2 = r_s1;
            n_s1 = i_ctrl.raw;
            if (r_s2 == r_s1 && r_s1 == i_ctrl.raw) begin
                if (r_acc != i_ctrl.raw) begin
                    n_acc = i_ctrl.raw;
                    if (i_ctrl.raw == i_cfg.pressed_level) begin
                        if (!r_rep) begin
                            n_sf  = 1'b1;
                            n_cnt = i_cfg.long_ticks;
                        end else begin
                            n_cnt = i_cfg.repeat_ticks;
                        end
                    end else begin
                        n_rep = 1'b0;
                    end
                end else begin
                    n_cnt = w_dec;
                    if (w_dec == '0 && i_ctrl.raw == i_cfg.pressed_level) begin
                        n_lf  = 1'b1;
                        n_acc = ~i_cfg.pressed_level;
                        n_rep = 1'b1;
                    end
                end
            end
        end
        if (i_ctrl.clr_sp) begin
            n_sf = 1'b0;
        end
        if (i_ctrl.clr_lp) begin
            n_lf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= RST_RELEASED;
            r_s2  <= RST_RELEASED;
            r_acc <= RST_RELEASED;
            r_rep <= 1'b0;
            r_sf  <= 1'b0;
            r_lf  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_acc <= n_acc;
            r_rep <= n_rep;
            r_sf  <= n_sf;
            r_lf  <= n_lf;
            r_cnt <= n_cnt;
        end
    end

    // The incoming level acts as the third sample, so two stored stages suffice.
    assign o_flags.sp_cur = r_sf;
    assign o_flags.lp_cur = r_lf;
    assign o_flags.sp_nxt = n_sf;
    assign o_flags.lp_nxt = n_lf;

endmodule

// ===== hw/rtl/dbl_merge.sv =====
// Merge stage: selects the query answer from the lanes, gathers the pending
// flags and holds the result beat in the output register. Depends on dbl_pkg.
module dbl_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic [dbl_pkg::FUNC_W-1:0]          i_func,
    input  logic [dbl_pkg::IDX_W-1:0]           i_index,
    input  dbl_pkg::t_lane_flags                i_flags [dbl_pkg::NUM_BUTTONS],
    input  logic                                i_out_ready,
    output logic                                o_can_take,
    output logic                                o_out_valid,
    output logic [7:0]                          o_out_data
);
    import dbl_pkg::*;

    logic                   r_valid;
    logic [7:0]             r_data;
    logic                   w_answer;
    logic [NUM_BUTTONS-1:0] w_sp, w_lp;

    always_comb begin
        w_answer = 1'b0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            w_sp[b] = i_flags[b].sp_nxt;
            w_lp[b] = i_flags[b].lp_nxt;
            if (i_index == IDX_W'(b)) begin
                if (i_func == FUNC_READ_SHORT) begin
                    w_answer = w_answer | i_flags[b].sp_cur;
                end else if (i_func == FUNC_READ_LONG) begin
                    w_answer = w_answer | i_flags[b].lp_cur;
                end
            end
        end
    end

    assign o_can_take = i_rst_n & (~r_valid | i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_data <= {1'b0, w_lp, w_sp, w_answer};
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ===== hw/rtl/button_debounce_long_press_top.sv =====
// Debounces three buttons in parallel lanes and reports short presses, long presses and
// auto-repeat. A lane updates all its state in the cycle the beat is accepted and the result beat
// is registered together with that state, so a new beat is accepted every cycle while the output
// side keeps taking results. A tick beat (tuser 0) shifts raw pin levels into the sample
// stages of each button; a level held for three ticks is accepted. Query beats (tuser 1 or 2)
// return and clear one button's short or long flag; button index 3 returns 0. Each result
// carries the pending flags of all buttons.
// Depends on dbl_pkg, dbl_lane, dbl_merge and assert_macros.svh.
`include "assert_macros.svh"

module button_debounce_long_press_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dbl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dbl_pkg::CNT_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] button_index, [4:2] raw_levels, [7:5] zero
    input  logic [7:0]                      s_axis_tdata,
    // [1:0] func
    input  logic [dbl_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] answer, [3:1] short_pending, [6:4] long_pending, [7] zero
    output logic [7:0]                      m_axis_tdata
);
    import dbl_pkg::*;

    t_cfg        r_cfg;
    logic        w_fire;
    logic        w_tick;
    t_lane_ctrl  w_ctrl  [NUM_BUTTONS];
    t_lane_flags w_flags [NUM_BUTTONS];
    logic [IDX_W-1:0] w_index;
    logic [2:0]       w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pressed_level <= RST_PRESSED_LEVEL;
            r_cfg.long_ticks    <= RST_LONG_TICKS;
            r_cfg.repeat_ticks  <= RST_REPEAT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRESSED_LEVEL: r_cfg.pressed_level <= i_cfg_data[0];
                CFG_LONG_TICKS:    r_cfg.long_ticks    <= i_cfg_data;
                CFG_REPEAT_TICKS:  r_cfg.repeat_ticks  <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign w_fire  = s_axis_tvalid & s_axis_tready;
    assign w_tick  = w_fire & (s_axis_tuser == FUNC_TICK);
    assign w_index = s_axis_tdata[1:0];
    assign w_raw   = s_axis_tdata[4:2];

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        assign w_ctrl[b].tick   = w_tick;
        assign w_ctrl[b].raw    = w_raw[b];
        assign w_ctrl[b].clr_sp = w_fire & (s_axis_tuser == FUNC_READ_SHORT)
                                  & (w_index == IDX_W'(b));
        assign w_ctrl[b].clr_lp = w_fire & (s_axis_tuser == FUNC_READ_LONG)
                                  & (w_index == IDX_W'(b));

        dbl_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_ctrl  (w_ctrl[b]),
            .o_flags (w_flags[b])
        );
    end

    dbl_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_func      (s_axis_tuser),
        .i_index     (w_index),
        .i_flags     (w_flags),
        .i_out_ready (m_axis_tready),
        .o_can_take  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    `DBL_ASSERT(a_no_overwrite, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "result beat would be overwritten")
    `DBL_ASSERT(a_fire_gives_result, w_fire |=> m_axis_tvalid, "accepted beat produced no result")
    `DBL_ASSERT(a_tick_answer_zero, w_tick |=> !m_axis_tdata[0], "tick beat returned a nonzero answer")
    `DBL_ASSERT_ALWAYS(a_no_take_in_reset, !i_rst_n |-> !s_axis_tready, "input taken during reset")

endmodule

// ===== sim/dbl_press_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the button debounce block: follows the config port and both stream
// channels, predicts every result beat and compares it field by field.
// Depends on dbl_pkg.
module dbl_press_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dbl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dbl_pkg::CNT_W-1:0]     i_cfg_data,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [7:0]                    i_s_tdata,
    input  logic [dbl_pkg::FUNC_W-1:0]    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [7:0]                    i_m_tdata,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_long_presses
);
    import dbl_pkg::*;

    typedef struct packed {
        logic                   answer;
        logic [NUM_BUTTONS-1:0] short_pending;
        logic [NUM_BUTTONS-1:0] long_pending;
    } t_press_report;

    t_cfg                   cfg;
    logic [NUM_BUTTONS-1:0] stage_one;
    logic [NUM_BUTTONS-1:0] stage_two;
    logic [NUM_BUTTONS-1:0] stage_three;
    logic [NUM_BUTTONS-1:0] accepted;
    logic [NUM_BUTTONS-1:0] repeat_on;
    logic [NUM_BUTTONS-1:0] short_flags;
    logic [NUM_BUTTONS-1:0] long_flags;
    logic [CNT_W-1:0]       hold_cnt [NUM_BUTTONS];
    t_press_report          report_q [$];
    int                     fail_total = 0;
    int                     checked_total = 0;
    int                     long_total = 0;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_checked      = 0;
        o_long_presses = 0;
    end

    function automatic t_press_report predict_report(input logic [FUNC_W-1:0] func,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [NUM_BUTTONS-1:0] raw);
        t_press_report rep;
        logic          lvl;
        rep = '0;
        case (func)
            FUNC_TICK: begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    stage_three[b] = stage_two[b];
                    stage_two[b]   = stage_one[b];
                    stage_one[b]   = raw[b];
                    if (stage_three[b] == stage_two[b] && stage_two[b] == stage_one[b]) begin
                        lvl = stage_one[b];
                        if (accepted[b] != lvl) begin
                            accepted[b] = lvl;
                            if (lvl == cfg.pressed_level) begin
                                if (!repeat_on[b]) begin
                                    short_flags[b] = 1'b1;
                                    hold_cnt[b]    = cfg.long_ticks;
                                end else begin
                                    hold_cnt[b] = cfg.repeat_ticks;
                                end
                            end else begin
                                repeat_on[b] = 1'b0;
                            end
                        end else begin
                            if (hold_cnt[b] != '0)
                                hold_cnt[b] = hold_cnt[b] - 1'b1;
                            if (hold_cnt[b] == '0 && lvl == cfg.pressed_level) begin
                                long_flags[b] = 1'b1;
                                accepted[b]   = ~cfg.pressed_level;
                                repeat_on[b]  = 1'b1;
                                long_total++;
                            end
                        end
                    end
                end
            end
            FUNC_READ_SHORT: begin
                if (idx < NUM_BUTTONS) begin
                    rep.answer       = short_flags[idx];
                    short_flags[idx] = 1'b0;
                end
            end
            FUNC_READ_LONG: begin
                if (idx < NUM_BUTTONS) begin
                    rep.answer      = long_flags[idx];
                    long_flags[idx] = 1'b0;
                end
            end
            default: ;
        endcase
        rep.short_pending = short_flags;
        rep.long_pending  = long_flags;
        return rep;
    endfunction

    task automatic check_field(input string field, input logic [NUM_BUTTONS-1:0] want,
                               input logic [NUM_BUTTONS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_press_report want;
        if (!i_rst_n) begin
            cfg.pressed_level = RST_PRESSED_LEVEL;
            cfg.long_ticks    = RST_LONG_TICKS;
            cfg.repeat_ticks  = RST_REPEAT_TICKS;
            stage_one         = {NUM_BUTTONS{RST_RELEASED}};
            stage_two         = {NUM_BUTTONS{RST_RELEASED}};
            stage_three       = {NUM_BUTTONS{RST_RELEASED}};
            accepted          = {NUM_BUTTONS{RST_RELEASED}};
            repeat_on         = '0;
            short_flags       = '0;
            long_flags        = '0;
            for (int b = 0; b < NUM_BUTTONS; b++)
                hold_cnt[b] = '0;
            report_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRESSED_LEVEL: cfg.pressed_level = i_cfg_data[0];
                    CFG_LONG_TICKS:    cfg.long_ticks    = i_cfg_data;
                    CFG_REPEAT_TICKS:  cfg.repeat_ticks  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                report_q.push_back(predict_report(i_s_tuser, i_s_tdata[1:0], i_s_tdata[4:2]));
            if (i_m_tvalid && i_m_tready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: result beat %0h arrived with nothing expected, expected none",
                             $time, i_m_tdata);
                    fail_total++;
                end else begin
                    want = report_q.pop_front();
                    check_field("answer", want.answer, i_m_tdata[0]);
                    check_field("short_pending", want.short_pending, i_m_tdata[3:1]);
                    check_field("long_pending", want.long_pending, i_m_tdata[6:4]);
                    checked_total++;
                end
            end
        end
        o_fail_count   <= fail_total;
        o_pending      <= report_q.size();
        o_checked      <= checked_total;
        o_long_presses <= long_total;
    end

endmodule

// ===== sim/tb_button_debounce_long_press_top.sv =====
`timescale 1ns / 1ps
// Testbench top for button_debounce_long_press_top: writes register settings, sends tick
// and query beats under several idle patterns and reports the verdict.
// Depends on dbl_pkg, dbl_press_checker and the block itself.
module tb_button_debounce_long_press_top;
    import dbl_pkg::*;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int BEATS_PER_SETTING = 220;
    localparam int SETTLE_CYCLES     = 4;
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int STALL_LIMIT       = 4000;
    localparam int MAX_HOLD_SPAN     = 90;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_pattern;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CNT_W-1:0]       cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;

    t_idle_pattern          idle_pattern = IDLE_NONE;
    int                     hold_off_reqs = 0;
    int                     hold_off_seen = 0;
    int                     stall_left = 0;
    int                     idle_cycles = 0;
    int                     beats_sent = 0;
    int                     settings_used = 1;
    logic [NUM_BUTTONS-1:0] held_raw = '0;
    int                     hold_left = 0;
    int                     hold_span = MAX_HOLD_SPAN;
    int                     fail_count;
    int                     pending;
    int                     checked;
    int                     long_presses;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    button_debounce_long_press_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dbl_press_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_long_presses (long_presses)
    );

    function automatic int idle_pct(input t_idle_pattern pattern, input bit receiver_side);
        case (pattern)
            IDLE_SENDER:   return receiver_side ? 0 : 87;
            IDLE_RECEIVER: return receiver_side ? 87 : 0;
            IDLE_BOTH:     return 18;
            default:       return 0;
        endcase
    endfunction

    // A hold-off request keeps the output side stalled long enough to back up the input.
    always @(posedge i_clk) begin
        if (hold_off_reqs != hold_off_seen) begin
            hold_off_seen <= hold_off_reqs;
            stall_left    <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(0, 99) >= idle_pct(idle_pattern, 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("No beat accepted for %0d cycles.", STALL_LIMIT);
        $display("** button_debounce_long_press_top: FAILED **");
        $finish;
    end

    task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                             input logic [NUM_BUTTONS-1:0] raw);
        while ($urandom_range(0, 99) < idle_pct(idle_pattern, 1'b0)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {3'b000, raw, idx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic pressed, input logic [CNT_W-1:0] long_t,
                                 input logic [CNT_W-1:0] rep_t, input t_idle_pattern pattern);
        int span;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_PRESSED_LEVEL, {15'($urandom), pressed});
        write_reg(CFG_LONG_TICKS, long_t);
        write_reg(CFG_REPEAT_TICKS, rep_t);
        write_reg(CFG_UNMAPPED, 16'($urandom));
        cfg_we       <= 1'b0;
        idle_pattern <= pattern;
        span = int'(long_t) + 3 * int'(rep_t) + 8;
        hold_span = (span > MAX_HOLD_SPAN) ? MAX_HOLD_SPAN : span;
        hold_left = 0;
        settings_used++;
    endtask

    // Ticks mostly hold one pin pattern for a while, so presses get through the debounce.
    task automatic send_random_beat();
        int                     roll;
        logic [FUNC_W-1:0]      func;
        logic [IDX_W-1:0]       idx;
        logic [NUM_BUTTONS-1:0] raw;
        roll = $urandom_range(0, 99);
        idx  = IDX_W'($urandom_range(0, 3));
        raw  = NUM_BUTTONS'($urandom_range(0, 7));
        if (roll < 22) begin
            func = ($urandom_range(0, 1) != 0) ? FUNC_READ_SHORT : FUNC_READ_LONG;
        end else if (roll < 25) begin
            func = FUNC_UNUSED;
        end else begin
            func = FUNC_TICK;
            if (hold_left == 0) begin
                held_raw  = NUM_BUTTONS'($urandom_range(0, 7));
                hold_left = $urandom_range(1, hold_span);
            end
            hold_left--;
            if ($urandom_range(0, 9) != 0)
                raw = held_raw;
        end
        send_beat(func, idx, raw);
    endtask

    task automatic run_phase(input int n_beats, input bit with_hold_off, input bit with_pause);
        for (int n = 0; n < n_beats; n++) begin
            if (with_hold_off && n == 60)
                hold_off_reqs <= hold_off_reqs + 1;
            if (with_pause && n == n_beats / 2)
                wait_until_drained();
            send_random_beat();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: pins low mean pressed and the pins start released.
        send_beat(FUNC_READ_SHORT, 2'd0, 3'b000);
        send_beat(FUNC_UNUSED, 2'd3, 3'b101);
        repeat (3) send_beat(FUNC_TICK, 2'd1, 3'b000);
        send_beat(FUNC_READ_SHORT, 2'd3, 3'b111);
        for (int b = 0; b < NUM_BUTTONS; b++)
            send_beat(FUNC_READ_SHORT, IDX_W'(b), 3'b000);
        repeat (3) send_beat(FUNC_TICK, 2'd2, 3'b111);

        // Zero hold times make long presses fire on every other stable pressed tick.
        apply_setting(1'b1, 16'd0, 16'd0, IDLE_NONE);
        repeat (3) send_beat(FUNC_TICK, 2'd0, 3'b000);
        repeat (6) send_beat(FUNC_TICK, 2'd3, 3'b111);
        for (int b = 0; b <= NUM_BUTTONS; b++)
            send_beat(FUNC_READ_LONG, IDX_W'(b), 3'b010);

        apply_setting(1'b0, 16'd5, 16'd2, IDLE_NONE);
        run_phase(BEATS_PER_SETTING, 1'b1, 1'b0);
        apply_setting(1'b1, 16'd1, 16'd1, IDLE_SENDER);
        run_phase(BEATS_PER_SETTING, 1'b0, 1'b0);
        apply_setting(1'b0, 16'd12, 16'd4, IDLE_RECEIVER);
        run_phase(BEATS_PER_SETTING, 1'b0, 1'b1);
        apply_setting(1'b1, 16'd0, 16'd0, IDLE_BOTH);
        run_phase(BEATS_PER_SETTING, 1'b0, 1'b0);
        apply_setting(1'b0, 16'hFFFF, 16'hFFFF, IDLE_NONE);
        run_phase(BEATS_PER_SETTING, 1'b0, 1'b0);
        apply_setting(1'b1, 16'd30, 16'hFFFF, IDLE_SENDER);
        run_phase(BEATS_PER_SETTING, 1'b0, 1'b0);
        apply_setting(1'b0, 16'd3, 16'd20, IDLE_RECEIVER);
        run_phase(BEATS_PER_SETTING, 1'b0, 1'b0);
        apply_setting(1'b1, 16'($urandom_range(1, 8)), 16'($urandom_range(0, 8)), IDLE_BOTH);
        run_phase(BEATS_PER_SETTING, 1'b0, 1'b0);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d beats over %0d register settings, both pressed levels and hold times",
                 beats_sent, settings_used);
        $display("from 0 to 65535; %0d results checked, %0d long presses predicted.",
                 checked, long_presses);
        if (fail_count == 0)
            $display("** button_debounce_long_press_top: PASSED **");
        else
            $display("** button_debounce_long_press_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dbl_pkg.sv
hw/rtl/dbl_lane.sv
hw/rtl/dbl_merge.sv
hw/rtl/button_debounce_long_press_top.sv
sim/dbl_press_checker.sv
sim/tb_button_debounce_long_press_top.sv
